// File: rtl/usv_pkg.sv
// Shared types and constants for the URN syntax checker.
// Holds the character class word passed from the front end to the parser
// and the error codes. No dependencies.
package usv_pkg;

  localparam int unsigned MAX_NID_LEN = 32;
  localparam int unsigned RUN_W       = 6;
  localparam int unsigned ERR_W       = 5;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [RUN_W-1:0] RUN_MAX  = {RUN_W{1'b1}};
  localparam logic [RUN_W-1:0] NID_MAX  = RUN_W'(MAX_NID_LEN);

  // Characters that steer the grammar get their own kind.
  typedef enum logic [3:0] {
    CK_OTHER,
    CK_COLON,
    CK_PCT,
    CK_QUEST,
    CK_HASH,
    CK_PLUS,
    CK_EQUAL,
    CK_MINUS,
    CK_DOT,
    CK_SLASH
  } kind_t;

  typedef struct packed {
    logic       is_end;
    kind_t      kind;
    logic       alpha;
    logic       alnum;
    logic       pchar;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic [2:0] urn_hit;  // bit i: letter i of "urn", either case
  } cls_t;

  // Handshake between the queue and the parser.
  typedef struct packed {
    logic valid;
    cls_t data;
  } qout_t;

  localparam logic [ERR_W-1:0] E_OK        = 5'd0;
  localparam logic [ERR_W-1:0] E_BAD_URI   = 5'd1;
  localparam logic [ERR_W-1:0] E_NOT_URN   = 5'd2;
  localparam logic [ERR_W-1:0] E_EMPTY     = 5'd3;
  localparam logic [ERR_W-1:0] E_NID_START = 5'd4;
  localparam logic [ERR_W-1:0] E_NO_NSS    = 5'd5;
  localparam logic [ERR_W-1:0] E_NID_LONG  = 5'd6;
  localparam logic [ERR_W-1:0] E_NID_CHAR  = 5'd7;
  localparam logic [ERR_W-1:0] E_NID_HYPH  = 5'd8;
  localparam logic [ERR_W-1:0] E_NID_SHORT = 5'd9;
  localparam logic [ERR_W-1:0] E_NSS_EMPTY = 5'd10;
  localparam logic [ERR_W-1:0] E_NSS_START = 5'd11;
  localparam logic [ERR_W-1:0] E_NSS_CHAR  = 5'd12;
  localparam logic [ERR_W-1:0] E_PCT       = 5'd13;
  localparam logic [ERR_W-1:0] E_BARE_Q    = 5'd14;
  localparam logic [ERR_W-1:0] E_Q_SEL     = 5'd16;
  localparam logic [ERR_W-1:0] E_RQ_CHAR   = 5'd17;
  localparam logic [ERR_W-1:0] E_FRAG_CHAR = 5'd18;

endpackage

// File: rtl/usv_front.sv
// Front end of the URN checker: takes input words and classifies each byte.
// Depends on usv_pkg for the class word.
module usv_front (
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic          in_tlast,
  input  logic          q_full,
  output logic          q_push,
  output usv_pkg::cls_t q_data
);
  import usv_pkg::*;

  logic is_upper, is_lower, is_digit, is_af;
  logic [7:0] low_c;

  always_comb begin
    low_c    = in_tdata | 8'h20;
    is_upper = (in_tdata >= 8'h41) && (in_tdata <= 8'h5A);
    is_lower = (in_tdata >= 8'h61) && (in_tdata <= 8'h7A);
    is_digit = (in_tdata >= 8'h30) && (in_tdata <= 8'h39);
    is_af    = (low_c >= 8'h61) && (low_c <= 8'h66);

    q_data.is_end  = in_tlast;
    q_data.alpha   = is_upper || is_lower;
    q_data.alnum   = is_upper || is_lower || is_digit;
    q_data.hex_ok  = is_digit || is_af;
    q_data.hex_val = is_digit ? in_tdata[3:0] : 4'(in_tdata[3:0] + 4'd9);
    q_data.urn_hit[0] = (is_upper || is_lower) && (low_c == 8'h75);
    q_data.urn_hit[1] = (is_upper || is_lower) && (low_c == 8'h72);
    q_data.urn_hit[2] = (is_upper || is_lower) && (low_c == 8'h6E);

    case (in_tdata)
      8'h3A:   q_data.kind = CK_COLON;
      8'h25:   q_data.kind = CK_PCT;
      8'h3F:   q_data.kind = CK_QUEST;
      8'h23:   q_data.kind = CK_HASH;
      8'h2B:   q_data.kind = CK_PLUS;
      8'h3D:   q_data.kind = CK_EQUAL;
      8'h2D:   q_data.kind = CK_MINUS;
      8'h2E:   q_data.kind = CK_DOT;
      8'h2F:   q_data.kind = CK_SLASH;
      default: q_data.kind = CK_OTHER;
    endcase

    case (in_tdata)
      8'h2D, 8'h2E, 8'h5F, 8'h7E, 8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29,
      8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D, 8'h3A, 8'h40:
        q_data.pchar = 1'b1;
      default:
        q_data.pchar = is_upper || is_lower || is_digit;
    endcase
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

endmodule

// File: rtl/usv_queue.sv
// Short queue of classified words between the front end and the parser.
// Depends on usv_pkg for the entry type and depth.
module usv_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  usv_pkg::cls_t push_data,
  output logic          full,
  input  logic          pop,
  output usv_pkg::qout_t head
);
  import usv_pkg::*;

  cls_t                mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]     count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop)
      count_nxt = count_r + 1'b1;
    else if (pop && !push)
      count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push)
      mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push)
        wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)
        rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  assign full       = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.data  = mem[rd_ptr_r];

endmodule

// File: rtl/usv_parse.sv
// Back end of the URN checker: grammar state machine and result register.
// Consumes classified words from usv_queue; depends on usv_pkg.
module usv_parse (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           scheme_ext,
  input  usv_pkg::qout_t head,
  output logic           pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata
);
  import usv_pkg::*;

  typedef enum logic [3:0] {
    PH_START, PH_SCHEME, PH_NID_FIRST, PH_NID_BODY, PH_NSS_FIRST,
    PH_NSS_BODY, PH_RQ_SELECT, PH_R_BODY, PH_Q_BODY, PH_FRAG
  } phase_t;

  phase_t           phase_r, phase_nxt, eff;
  logic [RUN_W-1:0] run_r, run_nxt;
  logic             prev_an_r, prev_an_nxt;
  logic             match_r, match_nxt;
  logic [1:0]       pct_r, pct_nxt;
  logic [3:0]       hi_r, hi_nxt;
  logic             pendq_r, pendq_nxt;
  logic [ERR_W-1:0] err_r, err_nxt, code;
  logic             oval_r, oval_nxt;
  logic [7:0]       odata_r, odata_nxt;
  cls_t             c;
  logic             slot_free;

  assign c         = head.data;
  assign slot_free = !oval_r || out_tready;
  // A character never waits on the output; only an end word needs the slot.
  assign pop       = head.valid && (!c.is_end || slot_free);

  always_comb begin
    if (err_r != E_OK)
      code = err_r;
    else if (pct_r != 2'd0)
      code = E_PCT;
    else begin
      case (phase_r)
        PH_START:     code = scheme_ext ? E_EMPTY : E_BAD_URI;
        PH_SCHEME:    code = E_BAD_URI;
        PH_NID_FIRST: code = E_EMPTY;
        PH_NID_BODY:  code = E_NO_NSS;
        PH_NSS_FIRST: code = E_NSS_EMPTY;
        PH_RQ_SELECT: code = E_BARE_Q;
        default:      code = E_OK;
      endcase
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    run_nxt     = run_r;
    prev_an_nxt = prev_an_r;
    match_nxt   = match_r;
    pct_nxt     = pct_r;
    hi_nxt      = hi_r;
    pendq_nxt   = pendq_r;
    err_nxt     = err_r;
    oval_nxt    = oval_r && !out_tready;
    odata_nxt   = odata_r;
    eff         = (phase_r == PH_START) ? (scheme_ext ? PH_NID_FIRST : PH_SCHEME)
                                        : phase_r;

    if (pop && c.is_end) begin
      oval_nxt    = 1'b1;
      odata_nxt   = {2'b00, code, code == E_OK};
      phase_nxt   = PH_START;
      run_nxt     = '0;
      prev_an_nxt = 1'b0;
      match_nxt   = 1'b1;
      pct_nxt     = 2'd0;
      hi_nxt      = 4'd0;
      pendq_nxt   = 1'b0;
      err_nxt     = E_OK;
    end else if (pop && err_r == E_OK) begin
      if (pct_r != 2'd0) begin
        // Hex digits still owed from an escape.
        if (!c.hex_ok)
          err_nxt = E_PCT;
        else if (pct_r == 2'd2) begin
          hi_nxt  = c.hex_val;
          pct_nxt = 2'd1;
        end else begin
          pct_nxt = 2'd0;
          if (hi_r == 4'd0 && c.hex_val == 4'd0)
            err_nxt = E_PCT;
        end
      end else begin
        phase_nxt = eff;
        case (eff)
          PH_SCHEME: begin
            if (run_r != '0 && c.kind == CK_COLON) begin
              if (match_r && run_r == RUN_W'(3))
                phase_nxt = PH_NID_FIRST;
              else
                err_nxt = E_NOT_URN;
            end else if ((run_r == '0) ? c.alpha
                         : (c.alnum || c.kind == CK_PLUS || c.kind == CK_MINUS ||
                            c.kind == CK_DOT)) begin
              if (!(run_r < RUN_W'(3) && c.urn_hit[run_r[1:0]]))
                match_nxt = 1'b0;
              if (run_r != RUN_MAX)
                run_nxt = run_r + 1'b1;
            end else begin
              err_nxt = E_BAD_URI;
            end
          end
          PH_NID_FIRST: begin
            if (c.alnum) begin
              run_nxt     = RUN_W'(1);
              prev_an_nxt = 1'b1;
              phase_nxt   = PH_NID_BODY;
            end else begin
              err_nxt = E_NID_START;
            end
          end
          PH_NID_BODY: begin
            if (c.kind == CK_COLON) begin
              if (!prev_an_r)
                err_nxt = E_NID_HYPH;
              else if (run_r < RUN_W'(2))
                err_nxt = E_NID_SHORT;
              else
                phase_nxt = PH_NSS_FIRST;
            end else if (c.alnum || c.kind == CK_MINUS) begin
              if (run_r >= NID_MAX)
                err_nxt = E_NID_LONG;
              else begin
                run_nxt     = run_r + 1'b1;
                prev_an_nxt = c.alnum;
              end
            end else begin
              err_nxt = E_NID_CHAR;
            end
          end
          PH_NSS_FIRST: begin
            if (c.kind == CK_PCT) begin
              pct_nxt   = 2'd2;
              phase_nxt = PH_NSS_BODY;
            end else if (c.pchar)
              phase_nxt = PH_NSS_BODY;
            else
              err_nxt = E_NSS_START;
          end
          PH_NSS_BODY: begin
            if (c.kind == CK_PCT)
              pct_nxt = 2'd2;
            else if (c.kind == CK_QUEST)
              phase_nxt = PH_RQ_SELECT;
            else if (c.kind == CK_HASH)
              phase_nxt = PH_FRAG;
            else if (!(c.pchar || c.kind == CK_SLASH))
              err_nxt = E_NSS_CHAR;
          end
          PH_RQ_SELECT: begin
            if (c.kind == CK_PLUS)
              phase_nxt = PH_R_BODY;
            else if (c.kind == CK_EQUAL)
              phase_nxt = PH_Q_BODY;
            else
              err_nxt = E_Q_SEL;
          end
          PH_R_BODY: begin
            // A '?' seen last may open the q-component; otherwise it was text.
            pendq_nxt = 1'b0;
            if (pendq_r && c.kind == CK_EQUAL)
              phase_nxt = PH_Q_BODY;
            else if (c.kind == CK_PCT)
              pct_nxt = 2'd2;
            else if (c.kind == CK_QUEST)
              pendq_nxt = 1'b1;
            else if (c.kind == CK_HASH)
              phase_nxt = PH_FRAG;
            else if (!(c.pchar || c.kind == CK_SLASH))
              err_nxt = E_RQ_CHAR;
          end
          PH_Q_BODY: begin
            if (c.kind == CK_PCT)
              pct_nxt = 2'd2;
            else if (c.kind == CK_HASH)
              phase_nxt = PH_FRAG;
            else if (!(c.pchar || c.kind == CK_SLASH || c.kind == CK_QUEST))
              err_nxt = E_RQ_CHAR;
          end
          default: begin
            if (c.kind == CK_PCT)
              pct_nxt = 2'd2;
            else if (!(c.pchar || c.kind == CK_SLASH || c.kind == CK_QUEST))
              err_nxt = E_FRAG_CHAR;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      run_r     <= '0;
      prev_an_r <= 1'b0;
      match_r   <= 1'b1;
      pct_r     <= 2'd0;
      hi_r      <= 4'd0;
      pendq_r   <= 1'b0;
      err_r     <= E_OK;
      oval_r    <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      run_r     <= run_nxt;
      prev_an_r <= prev_an_nxt;
      match_r   <= match_nxt;
      pct_r     <= pct_nxt;
      hi_r      <= hi_nxt;
      pendq_r   <= pendq_nxt;
      err_r     <= err_nxt;
      oval_r    <= oval_nxt;
    end
    odata_r <= odata_nxt;
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = odata_r;

endmodule

// File: rtl/urn_syntax_validator.sv
// URN syntax checker, one byte per input word.
//   The input channel carries one character of a URN string per word in
//   in_tdata; a word with in_tlast high closes the string (its data byte is
//   ignored). For each closing word one result word appears on the output
//   channel with the verdict bit and the first error code; characters give
//   no result. cfg_we/cfg_wdata set whether strings carry their own "urn:"
//   prefix; write it only while the block is idle.
// Flow:
//   One input word per cycle is taken while the queue is not full. The grammar
//   state machine retires one word per cycle from a four-entry queue, a closing
//   word only when the output slot is free; its result is registered after the
//   words queued ahead of it.
// Reset:
//   Synchronous active-low rst_n empties the queue, drops any result and
//   arms the parser for the start of a new string with the prefix expected.
// Stalls:
//   When out_tready is low the result word holds; characters behind it keep
//   being parsed, and only the next closing word waits, filling the queue
//   until in_tready drops.
// Depends on usv_pkg, usv_front, usv_queue and usv_parse.
module urn_syntax_validator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] ch
  input  logic       in_tlast,   // is_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] valid_res, [5:1] error_code, [7:6] zero
  input  logic       cfg_we,
  input  logic       cfg_wdata   // scheme_external
);
  import usv_pkg::*;

  logic   ext_r;
  logic   q_full, q_push, q_pop;
  cls_t   q_data;
  qout_t  q_head;

  always_ff @(posedge clk) begin
    if (!rst_n)
      ext_r <= 1'b0;
    else if (cfg_we)
      ext_r <= cfg_wdata;
  end

  usv_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  usv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head)
  );

  usv_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .scheme_ext (ext_r),
    .head       (q_head),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: rtl/usv_checker.sv
// Port-level checks for urn_syntax_validator, attached with a bind.
// Sees only the top-level ports; depends on nothing else.
module usv_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // A result word waiting for the receiver stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // The verdict bit agrees with the error code.
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[0] == (out_tdata[5:1] == 5'd0))
    else $error("verdict bit disagrees with error code");

  // Codes stay in the defined range and the pad bits are zero.
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[5:1] <= 5'd18 && out_tdata[7:6] == 2'b00)
    else $error("error code out of range");

  // Reset leaves no result pending and the input open.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

endmodule

bind urn_syntax_validator usv_checker u_usv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
